>>> sv/sql_like_wildcard_matcher_defines.svh
// Assertion macros for the SQL LIKE wildcard matcher.
`ifndef SQL_LIKE_WILDCARD_MATCHER_DEFINES_SVH
`define SQL_LIKE_WILDCARD_MATCHER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define SQLLK_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sql like matcher: assertion failed");

// Next-cycle implication, disabled during reset
`define SQLLK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sql like matcher: assertion failed");

`else

`define SQLLK_ASSERT_NOW(label, clk, rst, ante, cons)
`define SQLLK_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> sv/sqllk_pkg.sv
// Shared types and constants for the SQL LIKE wildcard matcher.
package sqllk_pkg;

   // Wildcard bytes of a LIKE pattern
   localparam logic [7:0] CHAR_PERCENT    = 8'h25;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

   // Word widths on the stream ports
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   // What an input word carries
   typedef enum logic {
      MODE_PATTERN = 1'b0,
      MODE_SUBJECT = 1'b1
   } mode_type;

   // One input word, unpacked from the stream
   typedef struct packed {
      mode_type   mode;
      logic       has_char;
      logic [7:0] char_code;
      logic       last;
      logic       negate;
      logic       null_arg;
   } item_type;

endpackage

>>> sv/sqllk_closure.sv
// Percent-sign closure of a position set as a log-depth prefix network.
module sqllk_closure import sqllk_pkg::*; #(
   parameter int WIDTH = 33
) (
   input  logic [WIDTH-1:0] seed,    // positions active before closure
   input  logic [WIDTH-1:0] prop,    // bit j: an active j-1 also activates j
   output logic [WIDTH-1:0] closed
);

   localparam int LVLS = $clog2(WIDTH);

   logic [WIDTH-1:0] gen_lvl [0:LVLS];
   logic [WIDTH-1:0] prp_lvl [0:LVLS-1];

   assign gen_lvl[0] = seed;
   assign prp_lvl[0] = prop;

   // Combine spans of doubling length at each level
   for (genvar lvl = 0; lvl < LVLS; lvl++) begin : g_lvl
      localparam int DIST = 1 << lvl;
      for (genvar j = 0; j < WIDTH; j++) begin : g_bit
         if (j >= DIST) begin : g_comb
            assign gen_lvl[lvl+1][j] = gen_lvl[lvl][j]
                                     | (prp_lvl[lvl][j] & gen_lvl[lvl][j-DIST]);
            if (lvl < LVLS - 1) begin : g_prp
               assign prp_lvl[lvl+1][j] = prp_lvl[lvl][j] & prp_lvl[lvl][j-DIST];
            end
         end else begin : g_pass
            assign gen_lvl[lvl+1][j] = gen_lvl[lvl][j];
            if (lvl < LVLS - 1) begin : g_prp
               assign prp_lvl[lvl+1][j] = prp_lvl[lvl][j];
            end
         end
      end
   end

   assign closed = gen_lvl[LVLS];

endmodule

>>> sv/sqllk_pattern_store.sv
// Pattern store with length, overflow and loading state.
`include "sql_like_wildcard_matcher_defines.svh"
module sqllk_pattern_store import sqllk_pkg::*; #(
   parameter int MAX_PATTERN = 32,
   parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_fire,
   input  item_type               item,
   output logic [7:0]             pat_byte [MAX_PATTERN],
   output logic [MAX_PATTERN-1:0] pat_any,
   output logic [MAX_PATTERN-1:0] pat_one,
   output logic [MAX_PATTERN-1:0] pos_valid,
   output logic [LEN_W-1:0]       length,
   output logic                   overflow,
   output logic                   loading
);

   logic [7:0]             byte_ff [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] any_ff;
   logic [MAX_PATTERN-1:0] one_ff;
   logic [LEN_W-1:0]       length_ff, length_in;
   logic                   overflow_ff, overflow_in;
   logic                   loading_ff, loading_in;
   logic [LEN_W-1:0]       wr_idx;
   logic                   wr_en;
   logic                   is_pattern;

   assign is_pattern = item_fire && (item.mode == MODE_PATTERN);

   // Work out length, overflow and loading after this word
   always_comb begin
      length_in   = length_ff;
      overflow_in = overflow_ff;
      loading_in  = loading_ff;
      wr_en       = 1'b0;
      wr_idx      = length_ff;
      if (is_pattern) begin
         // a new pattern starts afresh
         if (!loading_ff) begin
            length_in   = '0;
            overflow_in = 1'b0;
            wr_idx      = '0;
         end
         if (item.has_char) begin
            if (length_in < LEN_W'(MAX_PATTERN)) begin
               wr_en     = 1'b1;
               length_in = length_in + LEN_W'(1);
            end else begin
               overflow_in = 1'b1;
            end
         end
         loading_in = !item.last;
      end else if (item_fire) begin
         loading_in = 1'b0;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff   <= '0;
         overflow_ff <= 1'b0;
         loading_ff  <= 1'b0;
      end else begin
         length_ff   <= length_in;
         overflow_ff <= overflow_in;
         loading_ff  <= loading_in;
      end
   end

   // Write the byte and its wildcard kind into the next free entry
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (wr_en && wr_idx == LEN_W'(i)) begin
            byte_ff[i] <= item.char_code;
            any_ff[i]  <= (item.char_code == CHAR_PERCENT);
            one_ff[i]  <= (item.char_code == CHAR_UNDERSCORE);
         end
      end
   end

   // Mark entries inside the loaded pattern
   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         pos_valid[i] = (LEN_W'(i) < length_ff);
      end
   end

   assign pat_byte = byte_ff;
   assign pat_any  = any_ff;
   assign pat_one  = one_ff;
   assign length   = length_ff;
   assign overflow = overflow_ff;
   assign loading  = loading_ff;

   `SQLLK_ASSERT_NOW(a_length_bound, clock, reset, 1'b1, length_ff <= LEN_W'(MAX_PATTERN))
   `SQLLK_ASSERT_NEXT(a_overflow_full, clock, reset, is_pattern && item.has_char && !wr_en,
                      overflow_ff && length_ff == LEN_W'(MAX_PATTERN))

endmodule

>>> sv/sqllk_active_set.sv
// Bit-parallel set of active pattern positions, advanced one subject byte per word.
module sqllk_active_set import sqllk_pkg::*; #(
   parameter int MAX_PATTERN = 32,
   parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_fire,
   input  item_type               item,
   input  logic [7:0]             pat_byte [MAX_PATTERN],
   input  logic [MAX_PATTERN-1:0] pat_any,
   input  logic [MAX_PATTERN-1:0] pat_one,
   input  logic [MAX_PATTERN-1:0] pos_valid,
   input  logic [LEN_W-1:0]       length,
   input  logic                   loading,
   output logic                   hit
);

   localparam int W = MAX_PATTERN + 1;

   logic [W-1:0] act_ff, act_in;   // raw set, closure applied on use
   logic [W-1:0] prop;
   logic [W-1:0] base_raw, base;
   logic [W-1:0] nxt, adv;
   logic [W-1:0] final_set;

   // An active '%' inside the pattern also activates the following position
   assign prop = {pos_valid & pat_any, 1'b0};

   // Restart at position zero while the pattern is still open
   assign base_raw = loading ? W'(1) : act_ff;

   sqllk_closure #(.WIDTH(W)) u_base_close (
      .seed   (base_raw),
      .prop   (prop),
      .closed (base)
   );

   // Advance every active position by the subject byte
   always_comb begin
      nxt = '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (base[i] && pos_valid[i]) begin
            if (pat_any[i]) begin
               nxt[i] = 1'b1;
            end else if (pat_one[i] || pat_byte[i] == item.char_code) begin
               nxt[i+1] = 1'b1;
            end
         end
      end
   end

   sqllk_closure #(.WIDTH(W)) u_adv_close (
      .seed   (nxt),
      .prop   (prop),
      .closed (adv)
   );

   // Match when the end of the pattern is active
   assign final_set = item.has_char ? adv : base;
   assign hit       = final_set[length];

   // Next raw set
   always_comb begin
      act_in = act_ff;
      if (item_fire) begin
         if (item.last) begin
            act_in = W'(1);
         end else if (item.mode == MODE_SUBJECT) begin
            act_in = item.has_char ? nxt : base_raw;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= W'(1);
      end else begin
         act_ff <= act_in;
      end
   end

endmodule

>>> sv/sql_like_wildcard_matcher.sv
// SQL LIKE wildcard matcher: top level with input and result registers.
//
// Usage: send the pattern as words with req_tuser = 0, one byte each, the
// final one with req_tlast; '%' matches any run of bytes, '_' exactly one.
// Then send the subject with req_tuser = 1, one byte per word, the final
// word with req_tlast, negate (NOT LIKE) and null_arg set as needed. An
// empty string is a single word with has_char = 0. The pattern is kept for
// any number of subjects. Only the final subject word gives a result word:
// matched, result_null and pattern_error (pattern longer than MAX_PATTERN).
// Result path: the final subject word is accepted into the input register,
// and the position update then feeds the result register, which drives
// rsp_tvalid.
// Throughput: one word per clock while nothing stalls; the whole position
// set is updated at once, so a new word is taken each cycle unless stalled.
// Reset: empty pattern, start position active, no result pending.
// Stall: while the result register is full and rsp_tready is low, pattern
// and non-final subject words still pass; a further final word waits in
// the input register and req_tready drops.
`include "sql_like_wildcard_matcher_defines.svh"
module sql_like_wildcard_matcher import sqllk_pkg::*; #(
   parameter int MAX_PATTERN = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [0] has_char, [8:1] char_code, [9] negate, [10] null_arg, rest zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] mode: 0 pattern byte, 1 subject byte
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] matched, [1] result_null, [2] pattern_error, rest zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);

   item_type               item_ff, item_in;
   logic                   item_valid_ff, item_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [2:0]             rsp_data_ff, rsp_data_in;
   logic                   produces, process;
   logic [7:0]             pat_byte [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] pat_any, pat_one, pos_valid;
   logic [LEN_W-1:0]       length;
   logic                   overflow, loading, hit;

   // Unpack the incoming word
   always_comb begin
      item_in.mode      = mode_type'(req_tuser);
      item_in.has_char  = req_tdata[0];
      item_in.char_code = req_tdata[8:1];
      item_in.last      = req_tlast;
      item_in.negate    = req_tdata[9];
      item_in.null_arg  = req_tdata[10];
   end

   // Process the registered word unless its result has nowhere to go
   assign produces   = item_ff.mode == MODE_SUBJECT && item_ff.last;
   assign process    = item_valid_ff && (!produces || !rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || process;

   // Input register
   assign item_valid_in = req_tready ? req_tvalid : item_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
   end

   sqllk_pattern_store #(.MAX_PATTERN(MAX_PATTERN), .LEN_W(LEN_W)) u_store (
      .clock     (clock),
      .reset     (reset),
      .item_fire (process),
      .item      (item_ff),
      .pat_byte  (pat_byte),
      .pat_any   (pat_any),
      .pat_one   (pat_one),
      .pos_valid (pos_valid),
      .length    (length),
      .overflow  (overflow),
      .loading   (loading)
   );

   sqllk_active_set #(.MAX_PATTERN(MAX_PATTERN), .LEN_W(LEN_W)) u_active (
      .clock     (clock),
      .reset     (reset),
      .item_fire (process),
      .item      (item_ff),
      .pat_byte  (pat_byte),
      .pat_any   (pat_any),
      .pat_one   (pat_one),
      .pos_valid (pos_valid),
      .length    (length),
      .loading   (loading),
      .hit       (hit)
   );

   // Form the result: null and overflow force no match
   always_comb begin
      rsp_data_in[0] = !(item_ff.null_arg || overflow) && (hit ^ item_ff.negate);
      rsp_data_in[1] = item_ff.null_arg;
      rsp_data_in[2] = overflow;
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (process && produces) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (process && produces) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-3){1'b0}}, rsp_data_ff};

   `SQLLK_ASSERT_NEXT(a_result_loaded, clock, reset, process && produces, rsp_valid_ff)
   `SQLLK_ASSERT_NOW(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_tready,
                     !(process && produces))
   `SQLLK_ASSERT_NOW(a_forced_miss, clock, reset, rsp_valid_ff && (rsp_data_ff[1] || rsp_data_ff[2]),
                     !rsp_data_ff[0])

endmodule

>>> tb/like_match_checker.sv
// Result predictor and scoreboard for the SQL LIKE wildcard matcher streams.
module like_match_checker import sqllk_pkg::*; #(
   parameter int MAX_PATTERN = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // [0] has_char, [8:1] char_code, [9] negate, [10] null_arg, rest zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] mode: 0 pattern byte, 1 subject byte
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] matched, [1] result_null, [2] pattern_error, rest zero
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                    errors,
   output int                    pending
);

   // How one stored pattern position matches a subject byte
   typedef enum logic [1:0] {
      SYM_LITERAL = 2'd0,
      SYM_ONE     = 2'd1,
      SYM_RUN     = 2'd2
   } sym_kind_type;

   // One result word; matched sits in the lowest bit
   typedef struct packed {
      logic pattern_error;
      logic result_null;
      logic matched;
   } verdict_type;

   sym_kind_type         pat_kind [MAX_PATTERN];
   logic [7:0]           pat_byte [MAX_PATTERN];
   int unsigned          pat_len;
   logic [MAX_PATTERN:0] live;
   logic                 too_long;
   logic                 loading;
   verdict_type          verdict_q [$];

   task automatic report(input string what);
      $display("like_match_checker: %s (at %0t)", what, $time);
      errors++;
   endtask

   // Let every live run position also enable the position after it
   function automatic void close_runs();
      for (int i = 0; i < pat_len; i++) begin
         if (live[i] && pat_kind[i] == SYM_RUN) live[i+1] = 1'b1;
      end
   endfunction

   function automatic void rewind();
      live    = '0;
      live[0] = 1'b1;
      close_runs();
   endfunction

   // Advance the live set by one subject byte
   function automatic void step_byte(input logic [7:0] code);
      logic [MAX_PATTERN:0] nxt;
      nxt = '0;
      for (int i = 0; i < pat_len; i++) begin
         if (live[i]) begin
            if (pat_kind[i] == SYM_RUN) nxt[i] = 1'b1;
            else if (pat_kind[i] == SYM_ONE || pat_byte[i] == code) nxt[i+1] = 1'b1;
         end
      end
      live = nxt;
      close_runs();
   endfunction

   function automatic void take_word(input item_type word);
      verdict_type v;
      logic        hit;
      if (word.mode == MODE_PATTERN) begin
         // Open a fresh pattern on its first word
         if (!loading) begin
            pat_len  = 0;
            too_long = 1'b0;
            loading  = 1'b1;
         end
         if (word.has_char) begin
            if (pat_len < MAX_PATTERN) begin
               if (word.char_code == CHAR_PERCENT) pat_kind[pat_len] = SYM_RUN;
               else if (word.char_code == CHAR_UNDERSCORE) pat_kind[pat_len] = SYM_ONE;
               else pat_kind[pat_len] = SYM_LITERAL;
               pat_byte[pat_len] = word.char_code;
               pat_len++;
            end else begin
               too_long = 1'b1;
            end
         end
         if (word.last) begin
            loading = 1'b0;
            rewind();
         end
      end else begin
         // A subject word closes any pattern still open
         if (loading) begin
            loading = 1'b0;
            rewind();
         end
         if (word.has_char) step_byte(word.char_code);
         if (word.last) begin
            hit = live[pat_len];
            if (word.null_arg || too_long) hit = 1'b0;
            else hit = hit ^ word.negate;
            v.matched       = hit;
            v.result_null   = word.null_arg;
            v.pattern_error = too_long;
            verdict_q = {verdict_q, v};
            rewind();
         end
      end
   endfunction

   // Compare results, then predict from accepted input words
   always @(posedge clock) begin
      verdict_type got;
      verdict_type want;
      item_type    word;
      if (reset) begin
         verdict_q.delete();
         pat_len  = 0;
         too_long = 1'b0;
         loading  = 1'b0;
         rewind();
         errors   = 0;
         pending  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = verdict_type'(rsp_tdata[2:0]);
            if (verdict_q.size() == 0) begin
               report("result word with no result expected");
            end else begin
               want = verdict_q.pop_front();
               if (got.matched !== want.matched)
                  report($sformatf("matched %b, expected %b", got.matched, want.matched));
               if (got.result_null !== want.result_null)
                  report($sformatf("result_null %b, expected %b",
                                   got.result_null, want.result_null));
               if (got.pattern_error !== want.pattern_error)
                  report($sformatf("pattern_error %b, expected %b",
                                   got.pattern_error, want.pattern_error));
            end
         end
         if (req_tvalid && req_tready) begin
            word.mode      = mode_type'(req_tuser);
            word.has_char  = req_tdata[0];
            word.char_code = req_tdata[8:1];
            word.last      = req_tlast;
            word.negate    = req_tdata[9];
            word.null_arg  = req_tdata[10];
            take_word(word);
         end
         pending = verdict_q.size();
      end
   end

endmodule

>>> tb/testbench.sv
// Top of the testbench: clock, reset, stream stimulus and the final verdict.
module testbench import sqllk_pkg::*;;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // [0] has_char, [8:1] char_code, [9] negate, [10] null_arg, rest zero
   logic [REQ_DATA_W-1:0] req_tdata;
   // [0] mode: 0 pattern byte, 1 subject byte
   logic                  req_tuser;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [0] matched, [1] result_null, [2] pattern_error, rest zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   int                    errors;
   int                    pending;

   int         words_sent;
   int         results_taken;
   logic [7:0] text_buf [$];
   logic [7:0] pat_text [$];

   sql_like_wildcard_matcher u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   like_match_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .errors     (errors),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Bias bytes towards wildcards and a tiny alphabet so matches happen
   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) return CHAR_PERCENT;
      else if (r < 4) return CHAR_UNDERSCORE;
      else if (r < 7) return 8'h61 + 8'($urandom_range(0, 2));
      else return 8'($urandom_range(0, 255));
   endfunction

   // Offer one word after a random gap and hold it until taken
   task automatic send_word(input mode_type mode, input logic has_char,
                            input logic [7:0] code, input logic last,
                            input logic neg, input logic nul);
      int gap;
      gap = (words_sent >= 150 && words_sent < 230) ? 0 : $urandom_range(0, 6);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tlast  <= last;
      req_tdata  <= {5'b0, nul, neg, code, has_char};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
   endtask

   // Send text_buf as one string, with the odd byteless word mixed in
   task automatic send_text(input mode_type mode, input logic close,
                            input logic neg, input logic nul);
      int n;
      n = text_buf.size();
      if (n == 0) begin
         send_word(mode, 1'b0, pick_byte(), close, neg, nul);
      end else begin
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0)
               send_word(mode, 1'b0, pick_byte(), 1'b0, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            if (i == n - 1)
               send_word(mode, 1'b1, text_buf[i], close, neg, nul);
            else
               send_word(mode, 1'b1, text_buf[i], 1'b0, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
         end
      end
   endtask

   // Hold off the sender until every expected result has come
   task automatic wait_results(output bit ok);
      int n;
      ok = 1'b1;
      n  = 0;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0 && n < 5000) begin
         @(negedge clock);
         n++;
      end
      if (pending != 0) ok = 1'b0;
   endtask

   // Build a subject that mostly fits the current pattern
   task automatic make_subject();
      text_buf.delete();
      foreach (pat_text[i]) begin
         if (pat_text[i] == CHAR_PERCENT) begin
            repeat ($urandom_range(0, 3)) text_buf = {text_buf, pick_byte()};
         end else if (pat_text[i] == CHAR_UNDERSCORE) begin
            text_buf = {text_buf, pick_byte()};
         end else begin
            text_buf = {text_buf, pat_text[i]};
         end
      end
      if ($urandom_range(0, 9) < 3) begin
         case ($urandom_range(0, 2))
            0: if (text_buf.size() > 0)
                  text_buf[$urandom_range(0, text_buf.size() - 1)] = pick_byte();
            1: text_buf = {text_buf, pick_byte()};
            default: if (text_buf.size() > 0) void'(text_buf.pop_back());
         endcase
      end
   endtask

   // Result side: random stalls, a quiet stretch and two long hold-offs
   initial begin
      int w;
      rsp_tready    = 1'b0;
      results_taken = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (results_taken == 15 || results_taken == 50) w = 300;
         else if (results_taken >= 30 && results_taken < 45) w = 0;
         else w = $urandom_range(0, 6);
         if (w > 0) begin
            rsp_tready <= 1'b0;
            repeat (w) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         results_taken++;
         @(negedge clock);
      end
   end

   // Stimulus and verdict
   initial begin
      bit ok;
      bit paused;
      int r;
      int patterns;
      int len;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = MODE_PATTERN;
      req_tlast  = 1'b0;
      words_sent = 0;
      paused     = 1'b0;
      patterns   = 0;
      reset      = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty pattern after reset: empty subject matches, one byte does not (sent with NOT LIKE)
      send_word(MODE_SUBJECT, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0);
      send_word(MODE_SUBJECT, 1'b1, 8'h78, 1'b1, 1'b1, 1'b0);
      // Wildcard pattern, literal percent in the subject, negation and null
      text_buf = '{8'h61, CHAR_PERCENT, CHAR_UNDERSCORE};
      send_text(MODE_PATTERN, 1'b1, 1'b0, 1'b0);
      text_buf = '{8'h61, CHAR_PERCENT};
      send_text(MODE_SUBJECT, 1'b1, 1'b0, 1'b0);
      send_word(MODE_SUBJECT, 1'b1, 8'h61, 1'b1, 1'b0, 1'b0);
      send_word(MODE_SUBJECT, 1'b1, 8'h61, 1'b1, 1'b1, 1'b0);
      send_word(MODE_SUBJECT, 1'b1, 8'h61, 1'b1, 1'b1, 1'b1);
      // Extreme byte values with a byteless word inside the pattern
      send_word(MODE_PATTERN, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
      send_word(MODE_PATTERN, 1'b0, 8'hFF, 1'b0, 1'b1, 1'b1);
      send_word(MODE_PATTERN, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0);
      send_word(MODE_SUBJECT, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
      send_word(MODE_SUBJECT, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0);
      // Subject arriving while the pattern is still open
      send_word(MODE_PATTERN, 1'b1, 8'h71, 1'b0, 1'b0, 1'b0);
      send_word(MODE_PATTERN, 1'b1, CHAR_PERCENT, 1'b0, 1'b0, 1'b0);
      send_word(MODE_SUBJECT, 1'b1, 8'h71, 1'b1, 1'b0, 1'b0);
      // Pattern arriving in the middle of a subject
      send_word(MODE_SUBJECT, 1'b1, 8'h7A, 1'b0, 1'b0, 1'b0);
      send_word(MODE_PATTERN, 1'b1, CHAR_UNDERSCORE, 1'b1, 1'b0, 1'b0);
      send_word(MODE_SUBJECT, 1'b1, 8'h6B, 1'b1, 1'b0, 1'b0);
      wait_results(ok);

      // Random part: mostly pattern and subject sequences, some noise
      pat_text = '{CHAR_UNDERSCORE};
      while (words_sent < 520) begin
         if (!paused && words_sent >= 260) begin
            paused = 1'b1;
            wait_results(ok);
         end
         r = $urandom_range(0, 99);
         if (r < 12) begin
            repeat ($urandom_range(1, 4))
               send_word(mode_type'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else begin
            if (r < 40) begin
               patterns++;
               len = (patterns % 8 == 0) ? $urandom_range(29, 36) : $urandom_range(0, 8);
               pat_text.delete();
               repeat (len) pat_text = {pat_text, pick_byte()};
               text_buf = pat_text;
               send_text(MODE_PATTERN, $urandom_range(0, 9) != 0,
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            repeat ($urandom_range(1, 3)) begin
               make_subject();
               send_text(MODE_SUBJECT, $urandom_range(0, 9) != 0,
                         1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0);
            end
         end
      end

      // Drain and give the verdict
      wait_results(ok);
      repeat (8) @(negedge clock);
      if (!ok || errors != 0 || pending != 0) $display("tb: failure");
      else $display("tb: success");
      $finish;
   end

   // Watchdog for a hung run
   initial begin
      #4000000;
      $display("tb: failure");
      $finish;
   end

endmodule

>>> sim.f
+incdir+sv
sv/sqllk_pkg.sv
sv/sqllk_closure.sv
sv/sqllk_pattern_store.sv
sv/sqllk_active_set.sv
sv/sql_like_wildcard_matcher.sv
tb/like_match_checker.sv
tb/testbench.sv
